FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define SLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define SLT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/slt_pkg.sv
// Types, constants and helper functions for the shell line tokenizer.
package slt_pkg;

    localparam int FIELD_W         = 12;
    localparam logic [FIELD_W-1:0] FIELD_MAX = 12'd4095;
    localparam int MAX_LINE_DEF    = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_BAR    = 8'h7c;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_SQUOTE,
        MODE_DQUOTE
    } lex_mode_t;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_AMP,
        PEND_SEMI,
        PEND_BAR
    } pend_t;

    typedef enum logic [1:0] {
        KIND_WORD = 2'd0,
        KIND_OP   = 2'd1,
        KIND_END  = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        OP_AND_AND = 4'd0,
        OP_AMP     = 4'd1,
        OP_DSEMI   = 4'd2,
        OP_SEMI    = 4'd3,
        OP_LPAREN  = 4'd4,
        OP_RPAREN  = 4'd5,
        OP_OR_OR   = 4'd6,
        OP_BAR_AMP = 4'd7,
        OP_BAR     = 4'd8,
        OP_NEWLINE = 4'd9
    } op_code_t;

    typedef enum logic [3:0] {
        CC_END,
        CC_BLANK,
        CC_LPAREN,
        CC_RPAREN,
        CC_NEWLINE,
        CC_AMP,
        CC_SEMI,
        CC_BAR,
        CC_SQUOTE,
        CC_DQUOTE,
        CC_OTHER
    } char_class_t;

    typedef struct packed {
        kind_t                kind;
        op_code_t             op;
        logic [FIELD_W-1:0]   start;
        logic [FIELD_W-1:0]   len;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t res0;
        result_t res1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cc;
        case (c)
            CH_NUL:    cc = CC_END;
            CH_SPACE:  cc = CC_BLANK;
            CH_TAB:    cc = CC_BLANK;
            CH_LT:     cc = CC_BLANK;
            CH_GT:     cc = CC_BLANK;
            CH_LPAREN: cc = CC_LPAREN;
            CH_RPAREN: cc = CC_RPAREN;
            CH_NL:     cc = CC_NEWLINE;
            CH_AMP:    cc = CC_AMP;
            CH_SEMI:   cc = CC_SEMI;
            CH_BAR:    cc = CC_BAR;
            CH_SQUOTE: cc = CC_SQUOTE;
            CH_DQUOTE: cc = CC_DQUOTE;
            default:   cc = CC_OTHER;
        endcase
        return cc;
    endfunction

    function automatic op_code_t single_op(input pend_t p);
        op_code_t op;
        case (p)
            PEND_AMP:  op = OP_AMP;
            PEND_SEMI: op = OP_SEMI;
            PEND_BAR:  op = OP_BAR;
            default:   op = OP_AND_AND;
        endcase
        return op;
    endfunction

endpackage

FILE: hw/rtl/slt_front.sv
// Front end: accepts bytes, classifies them and builds result requests.
module slt_front #(
    parameter int MAX_LINE = slt_pkg::MAX_LINE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_code,
    input  slt_pkg::q_status_t q_status,
    output logic               push,
    output slt_pkg::entry_t    push_entry
);
    import slt_pkg::*;

    localparam int POS_W = $clog2(MAX_LINE + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);

    lex_mode_t        mode_reg, mode_next;
    pend_t            pend_reg, pend_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] wstart_reg, wstart_next;

    logic             accept;
    char_class_t      cc;
    logic [POS_W-1:0] word_len;
    logic [POS_W-1:0] pos_adv;
    result_t          word_res;
    result_t          pre_res, post_res;
    logic             pre_valid, post_valid;
    logic             pair_hit;
    op_code_t         pair_op;

    function automatic logic [FIELD_W-1:0] clamp_field(input logic [POS_W-1:0] v);
        logic [POS_W+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, v};
        return (w > (POS_W+FIELD_W)'(FIELD_MAX)) ? FIELD_MAX : w[FIELD_W-1:0];
    endfunction

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign cc       = classify(char_code);
    assign word_len = (pos_reg >= wstart_reg) ? (pos_reg - wstart_reg) : '0;
    assign pos_adv  = (pos_reg == POS_MAX) ? pos_reg : (pos_reg + 1'b1);

    always_comb
    begin
        pair_hit = 1'b0;
        pair_op  = OP_AND_AND;
        case (pend_reg)
            PEND_AMP:
            begin
                pair_hit = (cc == CC_AMP);
                pair_op  = OP_AND_AND;
            end
            PEND_SEMI:
            begin
                pair_hit = (cc == CC_SEMI);
                pair_op  = OP_DSEMI;
            end
            PEND_BAR:
            begin
                pair_hit = (cc == CC_BAR) || (cc == CC_AMP);
                pair_op  = (cc == CC_BAR) ? OP_OR_OR : OP_BAR_AMP;
            end
            default:
            begin
                pair_hit = 1'b0;
                pair_op  = OP_AND_AND;
            end
        endcase
    end

    always_comb
    begin
        word_res = '{kind: KIND_WORD, op: OP_AND_AND, start: clamp_field(wstart_reg),
                     len: clamp_field(word_len), last: 1'b0};
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        pos_next    = pos_adv;
        wstart_next = wstart_reg;
        pre_valid   = 1'b0;
        post_valid  = 1'b0;
        pre_res     = '0;
        post_res    = '0;

        if (mode_reg == MODE_SQUOTE || mode_reg == MODE_DQUOTE)
        begin
            if (cc == CC_END)
            begin
                pre_valid      = 1'b1;
                pre_res        = word_res;
                pre_res.kind   = KIND_ERR;
                mode_next      = MODE_IDLE;
                pend_next      = PEND_NONE;
                pos_next       = '0;
                wstart_next    = '0;
            end
            else if ((mode_reg == MODE_SQUOTE && cc == CC_SQUOTE) ||
                     (mode_reg == MODE_DQUOTE && cc == CC_DQUOTE))
            begin
                mode_next = MODE_WORD;
            end
        end
        else if (pair_hit)
        begin
            pre_valid = 1'b1;
            pre_res   = '{kind: KIND_OP, op: pair_op, start: clamp_field(wstart_reg),
                          len: FIELD_W'(2), last: 1'b0};
            pend_next = PEND_NONE;
        end
        else
        begin
            if (pend_reg != PEND_NONE)
            begin
                pre_valid = 1'b1;
                pre_res   = '{kind: KIND_OP, op: single_op(pend_reg),
                              start: clamp_field(wstart_reg), len: FIELD_W'(1),
                              last: 1'b0};
                pend_next = PEND_NONE;
            end
            case (cc)
                CC_END, CC_BLANK, CC_LPAREN, CC_RPAREN, CC_NEWLINE,
                CC_AMP, CC_SEMI, CC_BAR:
                begin
                    if (mode_reg == MODE_WORD)
                    begin
                        pre_valid = 1'b1;
                        pre_res   = word_res;
                    end
                    mode_next = MODE_IDLE;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
            case (cc)
                CC_END:
                begin
                    post_valid  = 1'b1;
                    post_res    = '{kind: KIND_END, op: OP_AND_AND,
                                    start: clamp_field(pos_reg), len: '0, last: 1'b0};
                    pend_next   = PEND_NONE;
                    pos_next    = '0;
                    wstart_next = '0;
                end
                CC_LPAREN, CC_RPAREN, CC_NEWLINE:
                begin
                    post_valid = 1'b1;
                    post_res   = '{kind: KIND_OP,
                                   op: (cc == CC_LPAREN) ? OP_LPAREN :
                                       ((cc == CC_RPAREN) ? OP_RPAREN : OP_NEWLINE),
                                   start: clamp_field(pos_reg), len: FIELD_W'(1),
                                   last: 1'b0};
                end
                CC_AMP, CC_SEMI, CC_BAR:
                begin
                    pend_next   = (cc == CC_AMP) ? PEND_AMP :
                                  ((cc == CC_SEMI) ? PEND_SEMI : PEND_BAR);
                    wstart_next = pos_reg;
                end
                CC_SQUOTE, CC_DQUOTE, CC_OTHER:
                begin
                    if (mode_reg == MODE_IDLE)
                    begin
                        wstart_next = pos_reg;
                    end
                    mode_next = (cc == CC_SQUOTE) ? MODE_SQUOTE :
                                ((cc == CC_DQUOTE) ? MODE_DQUOTE : MODE_WORD);
                end
                default:
                begin
                    post_valid = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        push_entry = '0;
        if (pre_valid)
        begin
            push_entry.res0      = pre_res;
            push_entry.res1      = post_res;
            push_entry.two       = post_valid;
            push_entry.res0.last = !post_valid;
            push_entry.res1.last = 1'b1;
        end
        else
        begin
            push_entry.res0      = post_res;
            push_entry.res0.last = 1'b1;
        end
    end

    assign push = accept && (pre_valid || post_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= PEND_NONE;
            pos_reg    <= '0;
            wstart_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            pos_reg    <= pos_next;
            wstart_reg <= wstart_next;
        end
    end

endmodule

FILE: hw/rtl/slt_queue.sv
// Small queue of result requests between the front and back ends.
module slt_queue #(
    parameter int DEPTH = slt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  slt_pkg::entry_t    push_entry,
    input  logic               pop,
    output slt_pkg::entry_t    head,
    output slt_pkg::q_status_t status
);
    import slt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/slt_back.sv
// Back end: takes queued requests apart into single results on the output register.
module slt_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  slt_pkg::entry_t             head,
    input  slt_pkg::q_status_t          q_status,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  token_kind,
    output logic [3:0]                  operator_code,
    output logic [slt_pkg::FIELD_W-1:0] token_start,
    output logic [slt_pkg::FIELD_W-1:0] token_length,
    output logic                        last_of_run
);
    import slt_pkg::*;

    logic    out_valid_reg;
    logic    sub_reg;
    result_t res_reg;
    logic    load, take, entry_done;
    result_t sel_res;

    assign load       = !out_valid_reg || !out_stall;
    assign take       = load && !q_status.empty;
    assign entry_done = sub_reg || !head.two;
    assign pop        = take && entry_done;
    assign sel_res    = sub_reg ? head.res1 : head.res0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= !q_status.empty;
            end
            if (take)
            begin
                sub_reg <= !entry_done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= sel_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign token_kind    = res_reg.kind;
    assign operator_code = res_reg.op;
    assign token_start   = res_reg.start;
    assign token_length  = res_reg.len;
    assign last_of_run   = res_reg.last;

endmodule

FILE: hw/rtl/shell_line_tokenizer.sv
// Top level of the shell line tokenizer: front end, request queue and back end.
//
// Input channel: one byte of a command line per request on char_code, under
// in_valid / in_stall. Byte 0 ends the line; the next byte starts a new line at
// offset 0. Output channel: one token per request under out_valid / out_stall,
// with token_kind, operator_code, token_start, token_length and last_of_run.
// A byte gives zero, one or two tokens; last_of_run marks the final one.
// The first token of a byte passes the request queue and then the output
// register. Throughput: one byte per cycle while each byte gives at most one
// token and the output is not stalled; a two-token byte holds the single output
// register for both tokens in turn; the four-entry queue absorbs such bursts.
// in_stall rises only when the request queue is full.
// A stalled output holds its token; the front end keeps taking bytes until the
// queue fills.
// Reset clears the lexer state to between tokens at offset 0 and empties the
// queue and the output register.
module shell_line_tokenizer #(
    parameter int MAX_LINE    = slt_pkg::MAX_LINE_DEF,
    parameter int QUEUE_DEPTH = slt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  char_code,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  token_kind,
    output logic [3:0]                  operator_code,
    output logic [slt_pkg::FIELD_W-1:0] token_start,
    output logic [slt_pkg::FIELD_W-1:0] token_length,
    output logic                        last_of_run
);
    import slt_pkg::*;

    logic      push, pop;
    entry_t    push_entry, head;
    q_status_t q_status;

    slt_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    slt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    slt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .operator_code (operator_code),
        .token_start   (token_start),
        .token_length  (token_length),
        .last_of_run   (last_of_run)
    );

endmodule

FILE: hw/rtl/slt_checker.sv
// Port-level checker for the shell line tokenizer and its bind.
`include "assert_macros.svh"

module slt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [7:0]                  char_code,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [1:0]                  token_kind,
    input logic [3:0]                  operator_code,
    input logic [slt_pkg::FIELD_W-1:0] token_start,
    input logic [slt_pkg::FIELD_W-1:0] token_length,
    input logic                        last_of_run
);
    import slt_pkg::*;

    `SLT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "output request dropped while stalled")
    `SLT_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(token_kind) && $stable(operator_code) && $stable(token_start) && $stable(token_length) && $stable(last_of_run), "stalled output token changed")
    `SLT_ASSERT_IMPL(a_line_end_last, out_valid && (token_kind == KIND_END || token_kind == KIND_ERR), last_of_run, "line end token not marked last")
    `SLT_ASSERT_IMPL(a_op_code_zero, out_valid && token_kind != KIND_OP, operator_code == OP_AND_AND, "operator code set on non-operator token")
    `SLT_ASSERT_IMPL(a_end_len_zero, out_valid && token_kind == KIND_END, token_length == '0, "end token with nonzero length")

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (.*);

FILE: sim/shell_line_tokenizer_test.sv
// Self-checking testbench for the shell line tokenizer: directed and random command lines.
module shell_line_tokenizer_test;
    import slt_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_ITEMS = 360;
    localparam int unsigned LONG_BYTES   = 100;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          char_code;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          token_kind;
    logic [3:0]          operator_code;
    logic [FIELD_W-1:0]  token_start;
    logic [FIELD_W-1:0]  token_length;
    logic                last_of_run;

    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int          stall_left = 0;
    logic        calm = 1'b0;

    lex_mode_t   lex_state;
    logic [12:0] line_pos;
    logic [12:0] tok_start;
    pend_t       held_op;

    result_t     byte_tokens[$];
    result_t     expected_tokens[$];

    shell_line_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .operator_code (operator_code),
        .token_start   (token_start),
        .token_length  (token_length),
        .last_of_run   (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("shell_line_tokenizer_test: done, errors");
            $finish;
        end
    end

    function automatic logic [FIELD_W-1:0] sat_field(input logic [12:0] v);
        return (v > {1'b0, FIELD_MAX}) ? FIELD_MAX : v[FIELD_W-1:0];
    endfunction

    function automatic void append_token(input kind_t k, input op_code_t op,
                                         input logic [12:0] s, input logic [12:0] l);
        result_t r;
        r.kind  = k;
        r.op    = op;
        r.start = sat_field(s);
        r.len   = sat_field(l);
        r.last  = 1'b0;
        byte_tokens.push_back(r);
    endfunction

    function automatic void clear_line();
        lex_state = MODE_IDLE;
        line_pos  = '0;
        tok_start = '0;
        held_op   = PEND_NONE;
    endfunction

    function automatic void step_pos();
        if (line_pos < MAX_LINE_DEF)
            line_pos = line_pos + 13'd1;
    endfunction

    function automatic void close_word();
        if (lex_state == MODE_WORD)
            append_token(KIND_WORD, OP_AND_AND, tok_start, line_pos - tok_start);
        lex_state = MODE_IDLE;
    endfunction

    task automatic predict_tokens(input logic [7:0] c);
        op_code_t pair;
        op_code_t lone;
        logic     paired;
        byte_tokens.delete();
        paired = 1'b0;
        if (lex_state == MODE_SQUOTE || lex_state == MODE_DQUOTE)
        begin
            if (c == CH_NUL)
            begin
                append_token(KIND_ERR, OP_AND_AND, tok_start, line_pos - tok_start);
                clear_line();
            end
            else
            begin
                if ((lex_state == MODE_SQUOTE && c == CH_SQUOTE) ||
                    (lex_state == MODE_DQUOTE && c == CH_DQUOTE))
                    lex_state = MODE_WORD;
                step_pos();
            end
        end
        else
        begin
            if (held_op != PEND_NONE)
            begin
                paired = 1'b1;
                pair   = OP_AND_AND;
                if (held_op == PEND_AMP && c == CH_AMP)
                    pair = OP_AND_AND;
                else if (held_op == PEND_SEMI && c == CH_SEMI)
                    pair = OP_DSEMI;
                else if (held_op == PEND_BAR && c == CH_BAR)
                    pair = OP_OR_OR;
                else if (held_op == PEND_BAR && c == CH_AMP)
                    pair = OP_BAR_AMP;
                else
                begin
                    paired = 1'b0;
                    case (held_op)
                        PEND_AMP:  lone = OP_AMP;
                        PEND_SEMI: lone = OP_SEMI;
                        default:   lone = OP_BAR;
                    endcase
                    append_token(KIND_OP, lone, tok_start, 13'd1);
                end
                held_op = PEND_NONE;
                if (paired)
                begin
                    append_token(KIND_OP, pair, tok_start, 13'd2);
                    step_pos();
                end
            end
            if (!paired)
            begin
                case (c)
                    CH_NUL:
                    begin
                        close_word();
                        append_token(KIND_END, OP_AND_AND, line_pos, 13'd0);
                        clear_line();
                    end
                    CH_SPACE, CH_TAB, CH_LT, CH_GT:
                        close_word();
                    CH_LPAREN:
                    begin
                        close_word();
                        append_token(KIND_OP, OP_LPAREN, line_pos, 13'd1);
                    end
                    CH_RPAREN:
                    begin
                        close_word();
                        append_token(KIND_OP, OP_RPAREN, line_pos, 13'd1);
                    end
                    CH_NL:
                    begin
                        close_word();
                        append_token(KIND_OP, OP_NEWLINE, line_pos, 13'd1);
                    end
                    CH_AMP, CH_SEMI, CH_BAR:
                    begin
                        close_word();
                        held_op   = (c == CH_AMP) ? PEND_AMP :
                                    ((c == CH_SEMI) ? PEND_SEMI : PEND_BAR);
                        tok_start = line_pos;
                    end
                    CH_SQUOTE, CH_DQUOTE:
                    begin
                        if (lex_state == MODE_IDLE)
                            tok_start = line_pos;
                        lex_state = (c == CH_SQUOTE) ? MODE_SQUOTE : MODE_DQUOTE;
                    end
                    default:
                    begin
                        if (lex_state == MODE_IDLE)
                            tok_start = line_pos;
                        lex_state = MODE_WORD;
                    end
                endcase
                if (c != CH_NUL)
                    step_pos();
            end
        end
        if (byte_tokens.size() > 0)
            byte_tokens[byte_tokens.size() - 1].last = 1'b1;
        foreach (byte_tokens[i])
            expected_tokens.push_back(byte_tokens[i]);
    endtask

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid  <= 1'b0;
            char_code <= 8'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_tokens(c);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c inside {CH_TAB, CH_NL, CH_SPACE, CH_DQUOTE, CH_AMP, CH_SQUOTE,
                         CH_LPAREN, CH_RPAREN, CH_SEMI, CH_LT, CH_GT, CH_BAR});
        return c;
    endfunction

    task automatic send_quoted(input logic [7:0] q, input logic closed);
        logic [7:0] c;
        send_byte(q);
        repeat ($urandom_range(0, 5))
        begin
            do
                c = 8'($urandom_range(1, 255));
            while (c == q);
            send_byte(c);
        end
        if (closed)
            send_byte(q);
    endtask

    task automatic send_operator(input op_code_t op);
        case (op)
            OP_AND_AND: send_text("&&");
            OP_AMP:     send_byte(CH_AMP);
            OP_DSEMI:   send_text(";;");
            OP_SEMI:    send_byte(CH_SEMI);
            OP_LPAREN:  send_byte(CH_LPAREN);
            OP_RPAREN:  send_byte(CH_RPAREN);
            OP_OR_OR:   send_text("||");
            OP_BAR_AMP: send_text("|&");
            OP_BAR:     send_byte(CH_BAR);
            default:    send_byte(CH_NL);
        endcase
    endtask

    task automatic send_random_line();
        int unsigned pick;
        logic [7:0]  blanks[4];
        blanks = '{CH_SPACE, CH_TAB, CH_LT, CH_GT};
        repeat ($urandom_range(1, 8))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                repeat ($urandom_range(1, 6)) send_byte(word_byte());
            else if (pick < 50)
                send_quoted($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE, 1'b1);
            else if (pick < 75)
                send_operator(op_code_t'($urandom_range(0, 9)));
            else if (pick < 92)
                send_byte(blanks[$urandom_range(0, 3)]);
            else
                send_byte(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 9) == 0)
            send_quoted($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
        send_byte(CH_NUL);
    endtask

    task automatic test_words_and_blanks();
        send_text("a\t");
        send_byte(8'hff);
        send_byte(CH_LT);
        send_byte(CH_NUL);
    endtask

    task automatic test_operators();
        send_text("&&&;;;()||\n|&|");
        send_byte(CH_NUL);
    endtask

    task automatic test_quotes();
        send_text("'a|'>");
        send_byte(CH_NUL);
        send_byte(CH_DQUOTE);
        send_byte(CH_NUL);
    endtask

    task automatic test_long_lines();
        repeat (LONG_BYTES) send_byte(8'h61);
        send_text(" x(");
        send_byte(CH_NUL);
        send_byte(CH_SQUOTE);
        repeat (LONG_BYTES) send_byte(8'($urandom_range(1, 255)) | 8'h80);
        send_byte(CH_NUL);
    endtask

    task automatic test_random_lines();
        int unsigned goal;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 4) == 0)
                calm = !calm;
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(1, 255)));
                send_byte(CH_NUL);
            end
            else
                send_random_line();
            if ($urandom_range(0, 19) == 0)
            begin
                stop_sending();
                wait_drained();
            end
        end
        calm = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            out_stall <= 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 29)
                                                     : $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tokens.size() == 0)
            begin
                $display({"%0t: unexpected token, expected none, ",
                          "actual kind %0d op %0d start %0d len %0d last %0d"},
                         $time, token_kind, operator_code, token_start, token_length,
                         last_of_run);
                errors++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("token_kind", 12'(want.kind), 12'(token_kind));
                check_field("operator_code", 12'(want.op), 12'(operator_code));
                check_field("token_start", want.start, token_start);
                check_field("token_length", want.len, token_length);
                check_field("last_of_run", 12'(want.last), 12'(last_of_run));
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_code = 8'h00;
        out_stall = 1'b0;
        clear_line();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_words_and_blanks();
        stop_sending();
        wait_drained();
        test_operators();
        test_quotes();
        stop_sending();
        wait_drained();
        test_long_lines();
        test_random_lines();

        stop_sending();
        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("shell_line_tokenizer_test: done, clean");
        else
            $display("shell_line_tokenizer_test: done, errors");
        $finish;
    end
endmodule
